// ----- rtl/vntt_pkg.sv -----
`timescale 1ns / 1ps
package vntt_pkg;

   // fixed formats
   localparam int COEF_W      = 16;   // Q4.12 matrix coefficient
   localparam int COEF_FRAC   = 12;
   localparam int POS_FRAC    = 16;   // Q16.16
   localparam int HOLD_W      = 32;   // direction held in Q16.16
   localparam int CSR_DATA_W  = 64;
   localparam int CSR_INDEX_W = 3;

   localparam int POS_WIDTH_DEFAULT = 32;
   localparam int DIR_WIDTH_DEFAULT = 16;

   // squared length must exceed this (Q32.32) to be normalized
   localparam logic [63:0] LEN_SQ_LIMIT = 64'd4294;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LINEAR_A,
      CSR_LINEAR_B,
      CSR_LINEAR_NORMAL_MIX,
      CSR_NORMAL_A,
      CSR_NORMAL_B,
      CSR_OFFSET_XY,
      CSR_OFFSET_Z,
      CSR_MODE_FLAGS
   } csr_index_type;

   typedef struct packed {
      logic mirror;
      logic tan_on;
      logic nrm_on;
   } mode_flags_type;

   // saturate to a signed w-bit range
   function automatic logic signed [63:0] sat_w(input logic signed [63:0] v, input int w);
      logic signed [63:0] lim;
      lim = 64'sd1 <<< (w - 1);
      if (v > lim - 64'sd1) begin
         return lim - 64'sd1;
      end else if (v < -lim) begin
         return -lim;
      end
      return v;
   endfunction

   // round half up, then drop n fraction bits
   function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int n);
      return (v + ((64'sd1 <<< n) >>> 1)) >>> n;
   endfunction

   // latency of the normalize unit
   function automatic int norm_latency(input int dir_w);
      return HOLD_W + dir_w + 4;
   endfunction

endpackage

// ----- rtl/vertex_normal_tangent_transform_core.sv -----
`timescale 1ns / 1ps
// Channel   Ports                          Handshake
// request   start, busy, req_in_*          taken when start=1 and busy=0
// response  rsp_valid, rsp_out_*           rsp_valid marks each item, no backpressure
// control   csr_wr_en, csr_index, csr_wdata written on any edge with csr_wr_en=1
//
// One item enters per cycle; busy is always low. Most of the pipeline lies in
// the two normalize units in series: a 32-step square root and a DIR_WIDTH-1
// step divider each.
// Synchronous reset clears the configuration and valid registers and empties the pipeline.
// The pipeline never stalls; results appear exactly the latency after entry.
module vertex_normal_tangent_transform_core #(
   parameter int POS_WIDTH = vntt_pkg::POS_WIDTH_DEFAULT,
   parameter int DIR_WIDTH = vntt_pkg::DIR_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [POS_WIDTH-1:0]          req_in_pos_x,
   input  logic signed [POS_WIDTH-1:0]          req_in_pos_y,
   input  logic signed [POS_WIDTH-1:0]          req_in_pos_z,
   input  logic signed [DIR_WIDTH-1:0]          req_in_nrm_x,
   input  logic signed [DIR_WIDTH-1:0]          req_in_nrm_y,
   input  logic signed [DIR_WIDTH-1:0]          req_in_nrm_z,
   input  logic signed [DIR_WIDTH-1:0]          req_in_tan_x,
   input  logic signed [DIR_WIDTH-1:0]          req_in_tan_y,
   input  logic signed [DIR_WIDTH-1:0]          req_in_tan_z,
   input  logic signed [DIR_WIDTH-1:0]          req_in_tan_w,
   output logic                                 rsp_valid,
   output logic signed [POS_WIDTH-1:0]          rsp_out_pos_x,
   output logic signed [POS_WIDTH-1:0]          rsp_out_pos_y,
   output logic signed [POS_WIDTH-1:0]          rsp_out_pos_z,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_nrm_x,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_nrm_y,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_nrm_z,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_tan_x,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_tan_y,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_tan_z,
   output logic signed [DIR_WIDTH-1:0]          rsp_out_tan_w,
   input  logic                                 csr_wr_en,
   input  logic [vntt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vntt_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import vntt_pkg::*;

   localparam int NORM_LAT  = norm_latency(DIR_WIDTH);
   localparam int TOTAL_LAT = 2 + NORM_LAT + 4 + NORM_LAT + 1;
   localparam int P0W       = 3 + 7 * DIR_WIDTH;
   localparam int P1W       = P0W + 3 * POS_WIDTH + 3 * HOLD_W;
   localparam int P2W       = P0W + 3 * POS_WIDTH + 3 * DIR_WIDTH;
   localparam logic [DIR_WIDTH-1:0] ONE  = DIR_WIDTH'(1) << (DIR_WIDTH - 2);
   localparam logic [DIR_WIDTH-1:0] DMIN = DIR_WIDTH'(1) << (DIR_WIDTH - 1);

   // configuration registers
   logic [63:0]    lin_a_ff, lin_b_ff, mix_ff, nrm_a_ff, off_xy_ff;
   logic [31:0]    nrm_b_ff, off_z_ff;
   mode_flags_type mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_a_ff  <= '0;
         lin_b_ff  <= '0;
         mix_ff    <= '0;
         nrm_a_ff  <= '0;
         nrm_b_ff  <= '0;
         off_xy_ff <= '0;
         off_z_ff  <= '0;
         mode_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_LINEAR_A:          lin_a_ff  <= csr_wdata;
            CSR_LINEAR_B:          lin_b_ff  <= csr_wdata;
            CSR_LINEAR_NORMAL_MIX: mix_ff    <= csr_wdata;
            CSR_NORMAL_A:          nrm_a_ff  <= csr_wdata;
            CSR_NORMAL_B:          nrm_b_ff  <= csr_wdata[31:0];
            CSR_OFFSET_XY:         off_xy_ff <= csr_wdata;
            CSR_OFFSET_Z:          off_z_ff  <= csr_wdata[31:0];
            CSR_MODE_FLAGS:        mode_ff   <= mode_flags_type'(csr_wdata[2:0]);
            default: ;
         endcase
      end
   end

   // coefficient unpacking
   logic [2:0][2:0][COEF_W-1:0] lin_coef, nrm_coef;
   logic [2:0][HOLD_W-1:0]      offset;

   assign lin_coef[0][0] = lin_a_ff[15:0];
   assign lin_coef[0][1] = lin_a_ff[31:16];
   assign lin_coef[0][2] = lin_a_ff[47:32];
   assign lin_coef[1][0] = lin_a_ff[63:48];
   assign lin_coef[1][1] = lin_b_ff[15:0];
   assign lin_coef[1][2] = lin_b_ff[31:16];
   assign lin_coef[2][0] = lin_b_ff[47:32];
   assign lin_coef[2][1] = lin_b_ff[63:48];
   assign lin_coef[2][2] = mix_ff[15:0];
   assign nrm_coef[0][0] = mix_ff[31:16];
   assign nrm_coef[0][1] = mix_ff[47:32];
   assign nrm_coef[0][2] = mix_ff[63:48];
   assign nrm_coef[1][0] = nrm_a_ff[15:0];
   assign nrm_coef[1][1] = nrm_a_ff[31:16];
   assign nrm_coef[1][2] = nrm_a_ff[47:32];
   assign nrm_coef[2][0] = nrm_a_ff[63:48];
   assign nrm_coef[2][1] = nrm_b_ff[15:0];
   assign nrm_coef[2][2] = nrm_b_ff[31:16];
   assign offset[0] = off_xy_ff[31:0];
   assign offset[1] = off_xy_ff[63:32];
   assign offset[2] = off_z_ff;

   // request side
   logic                      accept;
   logic [2:0][POS_WIDTH-1:0] in_pos;
   logic [2:0][DIR_WIDTH-1:0] in_nrm, in_tan;
   logic [P0W-1:0]            p0_in;

   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign in_pos = {req_in_pos_z, req_in_pos_y, req_in_pos_x};
   assign in_nrm = {req_in_nrm_z, req_in_nrm_y, req_in_nrm_x};
   assign in_tan = {req_in_tan_z, req_in_tan_y, req_in_tan_x};
   assign p0_in  = {mode_ff, req_in_tan_w, in_tan, in_nrm};

   // matrix transforms
   logic                      xf_valid;
   logic [2:0][POS_WIDTH-1:0] xf_pos;
   logic [2:0][HOLD_W-1:0]    xf_nrm, xf_tan;
   logic [P0W-1:0]            xf_pl;

   vntt_xform #(.POS_WIDTH(POS_WIDTH), .DIR_WIDTH(DIR_WIDTH), .PW(P0W)) u_xform (
      .clock(clock), .reset(reset), .in_valid(accept),
      .in_pos(in_pos), .in_nrm(in_nrm), .in_tan(in_tan),
      .lin_coef(lin_coef), .nrm_coef(nrm_coef), .offset(offset),
      .in_pl(p0_in),
      .out_valid(xf_valid), .out_pos(xf_pos), .out_nrm(xf_nrm), .out_tan(xf_tan),
      .out_pl(xf_pl)
   );

   // normal normalize
   logic                      n1_valid;
   logic [2:0][DIR_WIDTH-1:0] n1_vec;
   logic [P1W-1:0]            n1_pl;

   vntt_norm #(.DIR_WIDTH(DIR_WIDTH), .PW(P1W)) u_norm_nrm (
      .clock(clock), .reset(reset), .in_valid(xf_valid), .in_vec(xf_nrm),
      .in_pl({xf_pl, xf_pos, xf_tan}),
      .out_valid(n1_valid), .out_vec(n1_vec), .out_long(), .out_pl(n1_pl)
   );

   logic [P0W-1:0]            p0_a;
   logic [2:0][POS_WIDTH-1:0] pos_a;
   logic [2:0][HOLD_W-1:0]    tt_a;
   logic [2:0][DIR_WIDTH-1:0] nout_a;
   mode_flags_type            flags_a;

   assign {p0_a, pos_a, tt_a} = n1_pl;
   assign flags_a = mode_flags_type'(p0_a[P0W-1 -: 3]);
   assign nout_a  = flags_a.nrm_on ? n1_vec : p0_a[3*DIR_WIDTH-1:0];

   // tangent orthogonalize
   logic                      or_valid;
   logic [2:0][HOLD_W-1:0]    or_tan;
   logic [P2W-1:0]            or_pl;

   vntt_ortho #(.DIR_WIDTH(DIR_WIDTH), .PW(P2W)) u_ortho (
      .clock(clock), .reset(reset), .in_valid(n1_valid), .in_tan(tt_a), .in_nrm(n1_vec),
      .in_pl({p0_a, pos_a, nout_a}),
      .out_valid(or_valid), .out_tan(or_tan), .out_pl(or_pl)
   );

   // tangent normalize
   logic                      n2_valid, n2_long;
   logic [2:0][DIR_WIDTH-1:0] n2_vec;
   logic [P2W-1:0]            n2_pl;

   vntt_norm #(.DIR_WIDTH(DIR_WIDTH), .PW(P2W)) u_norm_tan (
      .clock(clock), .reset(reset), .in_valid(or_valid), .in_vec(or_tan),
      .in_pl(or_pl),
      .out_valid(n2_valid), .out_vec(n2_vec), .out_long(n2_long), .out_pl(n2_pl)
   );

   // final select
   mode_flags_type            flags_b;
   logic [DIR_WIDTH-1:0]      w_b;
   logic [2:0][DIR_WIDTH-1:0] tv_b, nv_b, nrm_b;
   logic [2:0][POS_WIDTH-1:0] pos_b;
   logic                      tan_act;
   logic [2:0][DIR_WIDTH-1:0] tan_in;
   logic [DIR_WIDTH-1:0]      w_in;

   assign {flags_b, w_b, tv_b, nv_b, pos_b, nrm_b} = n2_pl;
   assign tan_act = flags_b.nrm_on && flags_b.tan_on;

   always_comb begin
      tan_in = tv_b;
      w_in   = w_b;
      if (tan_act) begin
         tan_in = n2_long ? n2_vec : {{DIR_WIDTH{1'b0}}, {DIR_WIDTH{1'b0}}, ONE};
         if (flags_b.mirror) begin
            w_in = (w_b == DMIN) ? ~DMIN : (~w_b + 1'b1);
         end
      end
   end

   // response register
   logic                      rsp_valid_ff;
   logic [2:0][POS_WIDTH-1:0] rsp_pos_ff;
   logic [2:0][DIR_WIDTH-1:0] rsp_nrm_ff, rsp_tan_ff;
   logic [DIR_WIDTH-1:0]      rsp_w_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= n2_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pos_ff <= pos_b;
      rsp_nrm_ff <= nrm_b;
      rsp_tan_ff <= tan_in;
      rsp_w_ff   <= w_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_pos_x = rsp_pos_ff[0];
   assign rsp_out_pos_y = rsp_pos_ff[1];
   assign rsp_out_pos_z = rsp_pos_ff[2];
   assign rsp_out_nrm_x = rsp_nrm_ff[0];
   assign rsp_out_nrm_y = rsp_nrm_ff[1];
   assign rsp_out_nrm_z = rsp_nrm_ff[2];
   assign rsp_out_tan_x = rsp_tan_ff[0];
   assign rsp_out_tan_y = rsp_tan_ff[1];
   assign rsp_out_tan_z = rsp_tan_ff[2];
   assign rsp_out_tan_w = rsp_w_ff;

   // every response traces back to an accepted item at fixed latency
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, TOTAL_LAT))
      else $error("response without matching request");

   // normal unit output lines up with transform output
   a_norm_latency: assert property (@(posedge clock) disable iff (reset)
      n1_valid |-> $past(xf_valid, NORM_LAT))
      else $error("normal unit latency mismatch");

   // degenerate tangent is replaced by the unit x axis
   a_degenerate: assert property (@(posedge clock) disable iff (reset)
      (n2_valid && tan_act && !n2_long) |=> (rsp_tan_ff[0] == ONE && rsp_tan_ff[1] == '0))
      else $error("degenerate tangent not replaced");

endmodule

// ----- rtl/vntt_xform.sv -----
`timescale 1ns / 1ps
module vntt_xform #(
   parameter int POS_WIDTH = vntt_pkg::POS_WIDTH_DEFAULT,
   parameter int DIR_WIDTH = vntt_pkg::DIR_WIDTH_DEFAULT,
   parameter int PW        = 1
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        in_valid,
   input  logic [2:0][POS_WIDTH-1:0]                   in_pos,
   input  logic [2:0][DIR_WIDTH-1:0]                   in_nrm,
   input  logic [2:0][DIR_WIDTH-1:0]                   in_tan,
   input  logic [2:0][2:0][vntt_pkg::COEF_W-1:0]       lin_coef,
   input  logic [2:0][2:0][vntt_pkg::COEF_W-1:0]       nrm_coef,
   input  logic [2:0][vntt_pkg::HOLD_W-1:0]            offset,
   input  logic [PW-1:0]                               in_pl,
   output logic                                        out_valid,
   output logic [2:0][POS_WIDTH-1:0]                   out_pos,
   output logic [2:0][vntt_pkg::HOLD_W-1:0]            out_nrm,
   output logic [2:0][vntt_pkg::HOLD_W-1:0]            out_tan,
   output logic [PW-1:0]                               out_pl
);
   import vntt_pkg::*;

   localparam int PPW = COEF_W + POS_WIDTH;
   localparam int DPW = COEF_W + DIR_WIDTH;
   localparam int SW  = PPW + 3;
   localparam int DSH = COEF_FRAC + (DIR_WIDTH - 2) - POS_FRAC;
   localparam logic signed [SW-1:0] PMAX = (SW'(1) <<< (POS_WIDTH - 1)) - SW'(1);
   localparam logic signed [SW-1:0] PMIN = -(SW'(1) <<< (POS_WIDTH - 1));

   logic signed [PPW-1:0] pp_ff [3][3], pp_in [3][3];
   logic signed [DPW-1:0] dn_ff [3][3], dn_in [3][3];
   logic signed [DPW-1:0] dt_ff [3][3], dt_in [3][3];
   logic                  v1_ff, v2_ff;
   logic [PW-1:0]         pl1_ff, pl2_ff;
   logic [2:0][POS_WIDTH-1:0]  pos_ff, pos_in;
   logic [2:0][HOLD_W-1:0]     nrm_ff, nrm_in, tan_ff, tan_in;

   // stage 1: all nine products per vector
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            pp_in[i][j] = PPW'($signed(lin_coef[i][j]) * $signed(in_pos[j]));
            dn_in[i][j] = DPW'($signed(nrm_coef[i][j]) * $signed(in_nrm[j]));
            dt_in[i][j] = DPW'($signed(lin_coef[i][j]) * $signed(in_tan[j]));
         end
      end
   end

   // stage 2: row sums, rounding, translation, saturation
   always_comb begin
      logic signed [SW-1:0] s;
      logic signed [SW-1:0] r;
      logic signed [63:0]   ds;
      for (int i = 0; i < 3; i++) begin
         s = SW'(pp_ff[i][0]) + SW'(pp_ff[i][1]) + SW'(pp_ff[i][2]);
         r = ((s + SW'(2 ** (COEF_FRAC - 1))) >>> COEF_FRAC) + SW'($signed(offset[i]));
         if (r > PMAX) begin
            r = PMAX;
         end else if (r < PMIN) begin
            r = PMIN;
         end
         pos_in[i] = POS_WIDTH'(r);
         ds = 64'(dn_ff[i][0]) + 64'(dn_ff[i][1]) + 64'(dn_ff[i][2]);
         nrm_in[i] = HOLD_W'(sat_w(rshift(ds, DSH), HOLD_W));
         ds = 64'(dt_ff[i][0]) + 64'(dt_ff[i][1]) + 64'(dt_ff[i][2]);
         tan_in[i] = HOLD_W'(sat_w(rshift(ds, DSH), HOLD_W));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      dn_ff  <= dn_in;
      dt_ff  <= dt_in;
      pl1_ff <= in_pl;
      pos_ff <= pos_in;
      nrm_ff <= nrm_in;
      tan_ff <= tan_in;
      pl2_ff <= pl1_ff;
   end

   assign out_valid = v2_ff;
   assign out_pos   = pos_ff;
   assign out_nrm   = nrm_ff;
   assign out_tan   = tan_ff;
   assign out_pl    = pl2_ff;

endmodule

// ----- rtl/vntt_norm.sv -----
`timescale 1ns / 1ps
module vntt_norm #(
   parameter int DIR_WIDTH = vntt_pkg::DIR_WIDTH_DEFAULT,
   parameter int PW        = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [2:0][vntt_pkg::HOLD_W-1:0]  in_vec,
   input  logic [PW-1:0]                     in_pl,
   output logic                              out_valid,
   output logic [2:0][DIR_WIDTH-1:0]         out_vec,
   output logic                              out_long,
   output logic [PW-1:0]                     out_pl
);
   import vntt_pkg::*;

   localparam int DIR_FRAC = DIR_WIDTH - 2;
   localparam int QW       = DIR_FRAC + 1;          // quotient never exceeds 1.0
   localparam int NW       = HOLD_W + QW;
   localparam int S        = HOLD_W;                // square root steps
   localparam int T_SUM    = 2;
   localparam int T_SETUP  = T_SUM + S + 1;
   localparam int T_OUT    = T_SETUP + QW + 1;
   localparam int LAT      = T_OUT + 1;
   localparam int SHR      = (DIR_FRAC <= POS_FRAC) ? POS_FRAC - DIR_FRAC : 0;
   localparam int SHL      = (DIR_FRAC > POS_FRAC) ? DIR_FRAC - POS_FRAC : 0;

   logic [LAT-1:0] vld_ff, vld_in;
   logic [PW-1:0]  pl_ff [0:LAT-1], pl_in [0:LAT-1];

   logic [2:0][HOLD_W-1:0]    mag_ff [0:T_SETUP-1], mag_in [0:T_SETUP-1];
   logic [2:0]                sgn_ff [0:T_OUT-1], sgn_in [0:T_OUT-1];
   logic [2:0][DIR_WIDTH-1:0] sht_ff [0:T_OUT-1], sht_in [0:T_OUT-1];
   logic                      ok_ff  [T_SUM:T_OUT-1], ok_in [T_SUM:T_OUT-1];
   logic [2:0][63:0]          sq_ff, sq_in;
   logic [63:0]               x_ff [0:S], x_in [0:S];
   logic [63:0]               r_ff [0:S], r_in [0:S];
   logic [2:0][NW-1:0]        rem_ff [0:QW], rem_in [0:QW];
   logic [2:0][QW-1:0]        q_ff [0:QW], q_in [0:QW];
   logic [HOLD_W-1:0]         dv_ff [0:QW], dv_in [0:QW];
   logic [2:0][DIR_WIDTH-1:0] res_ff, res_in;
   logic                      long_ff;

   // valid and side lines
   always_comb begin
      vld_in = {vld_ff[LAT-2:0], in_valid};
      pl_in[0] = in_pl;
      for (int k = 1; k < LAT; k++) begin
         pl_in[k] = pl_ff[k-1];
      end
      for (int k = 1; k < T_SETUP; k++) begin
         mag_in[k] = mag_ff[k-1];
      end
      for (int k = 1; k < T_OUT; k++) begin
         sgn_in[k] = sgn_ff[k-1];
         sht_in[k] = sht_ff[k-1];
      end
      for (int k = T_SUM + 1; k < T_OUT; k++) begin
         ok_in[k] = ok_ff[k-1];
      end
   end

   // entry: magnitude, sign, short-vector value
   always_comb begin
      logic signed [63:0] t64;
      for (int i = 0; i < 3; i++) begin
         sgn_in[0][i] = in_vec[i][HOLD_W-1];
         mag_in[0][i] = in_vec[i][HOLD_W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
         t64 = 64'($signed(in_vec[i])) <<< SHL;
         sht_in[0][i] = DIR_WIDTH'(sat_w(rshift(t64, SHR), DIR_WIDTH));
      end
   end

   // squares, then squared length
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sq_in[i] = 64'(mag_ff[0][i]) * 64'(mag_ff[0][i]);
      end
      x_in[0] = sq_ff[0] + sq_ff[1] + sq_ff[2];
      r_in[0] = '0;
      ok_in[T_SUM] = x_in[0] > LEN_SQ_LIMIT;
   end

   // integer square root, one result bit per stage
   always_comb begin
      logic [63:0] bitv;
      logic [63:0] trial;
      for (int k = 0; k < S; k++) begin
         bitv  = 64'(1) << (62 - 2 * k);
         trial = r_ff[k] + bitv;
         if (x_ff[k] >= trial) begin
            x_in[k+1] = x_ff[k] - trial;
            r_in[k+1] = (r_ff[k] >> 1) + bitv;
         end else begin
            x_in[k+1] = x_ff[k];
            r_in[k+1] = r_ff[k] >> 1;
         end
      end
   end

   // divide setup: numerator carries the half-divisor for rounding
   always_comb begin
      dv_in[0] = r_ff[S][HOLD_W-1:0];
      q_in[0]  = '0;
      for (int i = 0; i < 3; i++) begin
         rem_in[0][i] = (NW'(mag_ff[T_SETUP-1][i]) << DIR_FRAC)
                        + NW'(r_ff[S][HOLD_W-1:0] >> 1);
      end
   end

   // restoring divide, one quotient bit per stage
   always_comb begin
      logic [NW-1:0] dsh;
      for (int j = 0; j < QW; j++) begin
         dv_in[j+1] = dv_ff[j];
         dsh = NW'(dv_ff[j]) << (QW - 1 - j);
         for (int i = 0; i < 3; i++) begin
            rem_in[j+1][i] = rem_ff[j][i];
            q_in[j+1][i]   = q_ff[j][i];
            if (rem_ff[j][i] >= dsh) begin
               rem_in[j+1][i] = rem_ff[j][i] - dsh;
               q_in[j+1][i][QW-1-j] = 1'b1;
            end
         end
      end
   end

   // result select: normalized or short value
   always_comb begin
      logic [DIR_WIDTH-1:0] qv;
      for (int i = 0; i < 3; i++) begin
         qv = DIR_WIDTH'(q_ff[QW][i]);
         if (ok_ff[T_OUT-1]) begin
            res_in[i] = sgn_ff[T_OUT-1][i] ? (~qv + 1'b1) : qv;
         end else begin
            res_in[i] = sht_ff[T_OUT-1][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pl_ff   <= pl_in;
      mag_ff  <= mag_in;
      sgn_ff  <= sgn_in;
      sht_ff  <= sht_in;
      ok_ff   <= ok_in;
      sq_ff   <= sq_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      dv_ff   <= dv_in;
      res_ff  <= res_in;
      long_ff <= ok_ff[T_OUT-1];
   end

   assign out_valid = vld_ff[LAT-1];
   assign out_pl    = pl_ff[LAT-1];
   assign out_vec   = res_ff;
   assign out_long  = long_ff;

endmodule

// ----- rtl/vntt_ortho.sv -----
`timescale 1ns / 1ps
module vntt_ortho #(
   parameter int DIR_WIDTH = vntt_pkg::DIR_WIDTH_DEFAULT,
   parameter int PW        = 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   input  logic [2:0][vntt_pkg::HOLD_W-1:0]  in_tan,
   input  logic [2:0][DIR_WIDTH-1:0]         in_nrm,
   input  logic [PW-1:0]                     in_pl,
   output logic                              out_valid,
   output logic [2:0][vntt_pkg::HOLD_W-1:0]  out_tan,
   output logic [PW-1:0]                     out_pl
);
   import vntt_pkg::*;

   localparam int DIR_FRAC = DIR_WIDTH - 2;
   localparam int MW       = HOLD_W + DIR_WIDTH;

   logic [3:0]                v_ff;
   logic [PW-1:0]             pl_ff [4];
   logic signed [MW-1:0]      dp_ff [3], dp_in [3];
   logic signed [MW-1:0]      pn_ff [3], pn_in [3];
   logic [HOLD_W-1:0]         d_ff, d_in;
   logic [2:0][HOLD_W-1:0]    tt_ff [3];
   logic [2:0][DIR_WIDTH-1:0] nn_ff [2];
   logic [2:0][HOLD_W-1:0]    res_ff, res_in;

   always_comb begin
      logic signed [63:0] proj;
      // tangent dot normal products
      for (int i = 0; i < 3; i++) begin
         dp_in[i] = MW'($signed(in_tan[i]) * $signed(in_nrm[i]));
      end
      // dot product
      d_in = HOLD_W'(sat_w(rshift(64'(dp_ff[0]) + 64'(dp_ff[1]) + 64'(dp_ff[2]), DIR_FRAC),
                           HOLD_W));
      // projection along the normal
      for (int i = 0; i < 3; i++) begin
         pn_in[i] = MW'($signed(nn_ff[1][i]) * $signed(d_ff));
      end
      // subtract projection
      for (int i = 0; i < 3; i++) begin
         proj = sat_w(rshift(64'(pn_ff[i]), DIR_FRAC), HOLD_W);
         res_in[i] = HOLD_W'(sat_w(64'($signed(tt_ff[2][i])) - proj, HOLD_W));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      pl_ff[0] <= in_pl;
      pl_ff[1] <= pl_ff[0];
      pl_ff[2] <= pl_ff[1];
      pl_ff[3] <= pl_ff[2];
      tt_ff[0] <= in_tan;
      tt_ff[1] <= tt_ff[0];
      tt_ff[2] <= tt_ff[1];
      nn_ff[0] <= in_nrm;
      nn_ff[1] <= nn_ff[0];
      dp_ff    <= dp_in;
      d_ff     <= d_in;
      pn_ff    <= pn_in;
      res_ff   <= res_in;
   end

   assign out_valid = v_ff[3];
   assign out_pl    = pl_ff[3];
   assign out_tan   = res_ff;

endmodule
